@@ src/ntfs_runlist_decoder_assert.svh @@
// Assertion macros used by the runlist decoder top level.
`ifndef NTFS_RUNLIST_DECODER_ASSERT_SVH
`define NTFS_RUNLIST_DECODER_ASSERT_SVH

// Checks that a condition implies a consequence in the same cycle.
`define NRD_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence in the following cycle.
`define NRD_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

@@ src/nrd_pkg.sv @@
// Types and result codes shared by the runlist decoder modules.
package nrd_pkg;

    typedef enum logic [1:0] {
        KIND_RUN     = 2'd0,
        KIND_END     = 2'd1,
        KIND_CORRUPT = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       start_of_list;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        kind_t              kind;
        logic               list_done;
        logic        [63:0] run_vcn;
        logic signed [63:0] run_lcn;
        logic               run_is_hole;
        logic signed [63:0] run_length;
    } result_t;

endpackage

@@ src/nrd_in_stage.sv @@
// Input register that holds one stream byte until the decode stage takes it.
module nrd_in_stage
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          byte_valid,
    output logic          byte_stall,
    input  nrd_pkg::item_t item,
    input  logic          advance,
    output logic          pending,
    output nrd_pkg::item_t item_held
);
    import nrd_pkg::*;

    logic  pending_reg;
    logic  pending_next;
    item_t item_reg;
    logic  load;

    assign byte_stall = pending_reg && !advance;
    assign load       = byte_valid && !byte_stall;

    always_comb
    begin
        pending_next = pending_reg;
        if (load)
        begin
            pending_next = 1'b1;
        end
        else if (advance)
        begin
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
    end

    assign pending   = pending_reg;
    assign item_held = item_reg;

endmodule

@@ src/nrd_decode.sv @@
// Runlist state machine: gathers field bytes and computes each run's VCN and LCN.
module nrd_decode
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  nrd_pkg::item_t  item,
    output logic            res_fire,
    output nrd_pkg::result_t res
);
    import nrd_pkg::*;

    localparam logic [7:0]  NIBBLE_MASK   = 8'h0F;
    localparam logic [7:0]  SIGN_BIT_BYTE = 8'h80;
    localparam logic [63:0] HOLE_LCN      = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_OFFSET,
        PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next, phase_cur;
    logic [3:0]  lc_reg, lc_next;
    logic [3:0]  oc_reg, oc_next;
    logic [3:0]  idx_reg, idx_next;
    logic [63:0] len_reg, len_next;
    logic [63:0] delta_reg, delta_next;
    logic [63:0] prev_reg, prev_next, prev_cur;
    logic [63:0] vcn_reg, vcn_next, vcn_cur;

    logic [7:0]  b;
    logic [3:0]  idx_inc;
    logic [3:0]  count;
    logic        field_done;
    logic [63:0] acc_sel;
    logic [63:0] gathered;
    logic [63:0] extended;
    logic [63:0] run_len;
    logic [63:0] vcn_sum;
    logic [63:0] lcn_sum;

    function automatic logic [63:0] gather(input logic [63:0] acc, input logic [3:0] idx,
                                           input logic [7:0] val);
        logic [63:0] r;
        r = acc;
        for (int i = 0; i < 8; i++)
        begin
            if (idx == 4'(i))
            begin
                r[8*i +: 8] = r[8*i +: 8] | val;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] extend(input logic [63:0] acc, input logic [3:0] cnt,
                                           input logic [7:0] val);
        logic [63:0] r;
        r = acc;
        if (cnt < 4'd8 && (val & SIGN_BIT_BYTE) != 8'h00)
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (4'(i) >= cnt)
                begin
                    r[8*i +: 8] = 8'hFF;
                end
            end
        end
        return r;
    endfunction

    assign b          = item.in_byte;
    assign phase_cur  = item.start_of_list ? PH_HEADER : phase_reg;
    assign vcn_cur    = item.start_of_list ? 64'd0 : vcn_reg;
    assign prev_cur   = item.start_of_list ? 64'd0 : prev_reg;
    assign idx_inc    = idx_reg + 4'd1;
    assign count      = (phase_cur == PH_LENGTH) ? lc_reg : oc_reg;
    assign field_done = idx_inc >= count;
    assign acc_sel    = (phase_cur == PH_LENGTH) ? len_reg : delta_reg;
    assign gathered   = gather(acc_sel, idx_reg, b);
    assign extended   = field_done ? extend(gathered, count, b) : gathered;
    assign run_len    = (phase_cur == PH_LENGTH) ? extended : len_reg;
    assign vcn_sum    = vcn_cur + run_len;
    assign lcn_sum    = prev_cur + extended;

    always_comb
    begin
        phase_next      = phase_cur;
        lc_next         = lc_reg;
        oc_next         = oc_reg;
        idx_next        = idx_reg;
        len_next        = len_reg;
        delta_next      = delta_reg;
        prev_next       = prev_cur;
        vcn_next        = vcn_cur;
        res_fire        = 1'b0;
        res.kind        = KIND_RUN;
        res.list_done   = 1'b0;
        res.run_vcn     = 64'd0;
        res.run_lcn     = 64'sd0;
        res.run_is_hole = 1'b0;
        res.run_length  = 64'sd0;

        unique case (phase_cur)
            PH_HEADER:
            begin
                if (b == 8'h00)
                begin
                    phase_next    = PH_DONE;
                    res_fire      = 1'b1;
                    res.kind      = KIND_END;
                    res.list_done = 1'b1;
                end
                else
                begin
                    lc_next = 4'(b & NIBBLE_MASK);
                    oc_next = 4'((b >> 4) & NIBBLE_MASK);
                    if ((b & NIBBLE_MASK) == 8'h00 || item.last_byte)
                    begin
                        phase_next    = PH_DONE;
                        res_fire      = 1'b1;
                        res.kind      = KIND_CORRUPT;
                        res.list_done = 1'b1;
                    end
                    else
                    begin
                        idx_next   = 4'd0;
                        len_next   = 64'd0;
                        delta_next = 64'd0;
                        phase_next = PH_LENGTH;
                    end
                end
            end
            PH_LENGTH, PH_OFFSET:
            begin
                idx_next = idx_inc;
                if (phase_cur == PH_LENGTH)
                begin
                    len_next = extended;
                end
                else
                begin
                    delta_next = extended;
                end
                if (field_done && (phase_cur == PH_OFFSET || oc_reg == 4'd0))
                begin
                    res_fire        = 1'b1;
                    res.kind        = KIND_RUN;
                    res.list_done   = item.last_byte;
                    res.run_vcn     = vcn_cur;
                    res.run_length  = run_len;
                    vcn_next        = vcn_sum;
                    phase_next      = item.last_byte ? PH_DONE : PH_HEADER;
                    if (phase_cur == PH_OFFSET)
                    begin
                        res.run_lcn     = lcn_sum;
                        res.run_is_hole = 1'b0;
                        prev_next       = lcn_sum;
                    end
                    else
                    begin
                        res.run_lcn     = HOLE_LCN;
                        res.run_is_hole = 1'b1;
                    end
                end
                else if (item.last_byte)
                begin
                    phase_next    = PH_DONE;
                    res_fire      = 1'b1;
                    res.kind      = KIND_CORRUPT;
                    res.list_done = 1'b1;
                end
                else if (field_done)
                begin
                    idx_next   = 4'd0;
                    phase_next = PH_OFFSET;
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        if (!advance)
        begin
            res_fire = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            lc_reg    <= 4'd0;
            oc_reg    <= 4'd0;
            idx_reg   <= 4'd0;
            len_reg   <= 64'd0;
            delta_reg <= 64'd0;
            prev_reg  <= 64'd0;
            vcn_reg   <= 64'd0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            lc_reg    <= lc_next;
            oc_reg    <= oc_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
            delta_reg <= delta_next;
            prev_reg  <= prev_next;
            vcn_reg   <= vcn_next;
        end
    end

endmodule

@@ src/nrd_out_stage.sv @@
// Result register that presents one decoded run until the consumer takes it.
module nrd_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_fire,
    input  nrd_pkg::result_t res,
    input  logic             run_stall,
    output logic             run_valid,
    output logic             out_free,
    output nrd_pkg::result_t res_held
);
    import nrd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_free = !valid_reg || !run_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_fire)
        begin
            valid_next = 1'b1;
        end
        else if (!run_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            res_reg <= res;
        end
    end

    assign run_valid = valid_reg;
    assign res_held  = res_reg;

endmodule

@@ src/ntfs_runlist_decoder.sv @@
// Top level of the NTFS mapping-pairs runlist decoder.
// The block takes one mapping-pairs byte per cycle unless the input stalls, and reports
// each decoded run, the end of the list, or a corrupt stream as a single result
// transaction. Each byte is held in the input register, and any result that it completes
// is captured in the result register. The sustained rate is one byte per cycle, set by the
// decode stage, whose longest path is a byte merge into a 64-bit field followed by the
// 64-bit VCN and LCN additions. A byte can enter an empty input register while a result
// waits, and the input stalls only when a held result is itself stalled.
module ntfs_runlist_decoder
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  logic        [7:0]  in_byte,
    input  logic               start_of_list,
    input  logic               last_byte,
    output logic               run_valid,
    input  logic               run_stall,
    output logic        [1:0]  kind,
    output logic               list_done,
    output logic        [63:0] run_vcn,
    output logic signed [63:0] run_lcn,
    output logic               run_is_hole,
    output logic signed [63:0] run_length
);
    import nrd_pkg::*;

    item_t   item_in;
    item_t   item_held;
    logic    pending;
    logic    advance;
    logic    out_free;
    logic    res_fire;
    result_t res;
    result_t res_held;

    assign item_in.in_byte       = in_byte;
    assign item_in.start_of_list = start_of_list;
    assign item_in.last_byte     = last_byte;
    assign advance               = pending && out_free;

    nrd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .item       (item_in),
        .advance    (advance),
        .pending    (pending),
        .item_held  (item_held)
    );

    nrd_decode u_decode
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .item     (item_held),
        .res_fire (res_fire),
        .res      (res)
    );

    nrd_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_fire  (res_fire),
        .res       (res),
        .run_stall (run_stall),
        .run_valid (run_valid),
        .out_free  (out_free),
        .res_held  (res_held)
    );

    assign kind        = res_held.kind;
    assign list_done   = res_held.list_done;
    assign run_vcn     = res_held.run_vcn;
    assign run_lcn     = res_held.run_lcn;
    assign run_is_hole = res_held.run_is_hole;
    assign run_length  = res_held.run_length;

`include "ntfs_runlist_decoder_assert.svh"

    `NRD_ASSERT_NOW(a_stall_only_when_blocked, byte_stall,
        run_valid && run_stall && pending, "Input stalled while the result path could move.")
    `NRD_ASSERT_NEXT(a_accept_fills_input, byte_valid && !byte_stall, pending,
        "Accepted byte was not held in the input register.")
    `NRD_ASSERT_NOW(a_non_run_is_final, run_valid && kind != KIND_RUN,
        list_done && run_vcn == 64'd0 && run_lcn == 64'sd0 && !run_is_hole
            && run_length == 64'sd0,
        "End or corrupt result carries run data or is not final.")
    `NRD_ASSERT_NOW(a_hole_value, run_valid && run_is_hole,
        kind == KIND_RUN && run_lcn == -64'sd1, "Hole run without the hole LCN value.")

endmodule
